/* src/rwf_pkg.sv */
// Shared constants, types and register codes of the RGB 3x3 window filter.
package rwf_pkg;

	localparam int MAX_WIDTH      = 1024;
	localparam int MAX_HEIGHT     = 4096;
	localparam int COEF_FRAC_BITS = 12;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int EW      = COL_W + 1;
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int EH      = ROW_W + 1;

	localparam int NUM_CH   = 3;
	localparam int NUM_TAPS = 9;
	localparam int PIX_W    = 8;
	localparam int COEF_W   = 16;
	localparam int ROW_CFG_W = 3 * COEF_W;
	localparam int OFS_W    = 9;
	localparam int IMG_W_W  = 11;
	localparam int IMG_H_W  = 13;
	localparam int CFG_W    = 48;
	localparam int IDX_W    = 3;

	localparam int PROD_W = COEF_W + PIX_W + 1;
	localparam int SUM_W  = PROD_W + 4;
	localparam int Q_W    = SUM_W - COEF_FRAC_BITS;
	localparam int PIX_MAX = 255;
	localparam int MIN_DIM = 3;
	localparam int BORDER  = 2;

	localparam int LANE_LAT   = 5;
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef logic [NUM_CH*PIX_W-1:0] pixel_t;
	typedef pixel_t [NUM_TAPS-1:0] window_t;

	typedef struct packed {
		logic valid;
		logic last;
	} item_flags_t;

	typedef struct packed {
		logic [NUM_CH-1:0][PIX_W-1:0] ch;
		logic                         last;
	} result_t;

	typedef enum logic [IDX_W-1:0] {
		REG_COEF_TOP    = 3'd0,
		REG_COEF_MID    = 3'd1,
		REG_COEF_BOTTOM = 3'd2,
		REG_OFFSET      = 3'd3,
		REG_WIDTH       = 3'd4,
		REG_HEIGHT      = 3'd5
	} reg_idx_t;

endpackage

/* src/rwf_line_buf.sv */
// Raster counters, two line memories and the 3x3 pixel window.
module rwf_line_buf import rwf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  pixel_t               pix,
	input  logic [IMG_W_W-1:0]   img_width,
	input  logic [IMG_H_W-1:0]   img_height,
	output logic                 produce,
	output window_t              win,
	output item_flags_t          win_flags
);

	pixel_t mid_mem [MAX_WIDTH];
	pixel_t top_mem [MAX_WIDTH];

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [EW-1:0]    w_eff;
	logic [EH-1:0]    h_eff;
	logic             last_col;
	logic             last_row;

	logic             acc_s1;
	logic             prod_s1;
	logic             last_s1;
	logic [COL_W-1:0] col_s1;
	pixel_t           pix_s1;
	pixel_t           mid_rd_s1;
	pixel_t           top_rd_s1;

	window_t          win_q;
	item_flags_t      win_flags_q;

	always_comb begin
		if (img_width < IMG_W_W'(MIN_DIM)) begin
			w_eff = EW'(MIN_DIM);
		end else if (32'(img_width) > 32'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(img_width);
		end
		if (img_height < IMG_H_W'(MIN_DIM)) begin
			h_eff = EH'(MIN_DIM);
		end else if (32'(img_height) > 32'(MAX_HEIGHT)) begin
			h_eff = EH'(MAX_HEIGHT);
		end else begin
			h_eff = EH'(img_height);
		end
	end

	assign last_col = ({1'b0, col_q} + EW'(1)) >= w_eff;
	assign last_row = ({1'b0, row_q} + EH'(1)) >= h_eff;
	assign produce  = (row_q >= ROW_W'(BORDER)) && (col_q >= COL_W'(BORDER));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			acc_s1  <= 1'b0;
			prod_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			acc_s1  <= in_fire;
			prod_s1 <= produce;
			last_s1 <= last_col && last_row;
			if (in_fire) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// Read both lines at the incoming column; write them back in the following cycle.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mid_rd_s1 <= mid_mem[col_q];
			top_rd_s1 <= top_mem[col_q];
			pix_s1    <= pix;
			col_s1    <= col_q;
		end
		if (acc_s1) begin
			mid_mem[col_s1] <= pix_s1;
			top_mem[col_s1] <= mid_rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			win_flags_q <= '0;
		end else begin
			win_flags_q.valid <= acc_s1 && prod_s1;
			win_flags_q.last  <= last_s1;
			if (acc_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]     <= win_q[r*3 + 1];
					win_q[r*3 + 1] <= win_q[r*3 + 2];
				end
				win_q[2] <= top_rd_s1;
				win_q[5] <= mid_rd_s1;
				win_q[8] <= pix_s1;
			end
		end
	end

	assign win       = win_q;
	assign win_flags = win_flags_q;

endmodule

/* src/rwf_lane.sv */
// One channel lane: 3x3 multiply-accumulate, truncation, offset and saturation.
module rwf_lane import rwf_pkg::*; (
	input  logic                                clk,
	input  logic [NUM_TAPS-1:0][PIX_W-1:0]      taps,
	input  logic [NUM_TAPS-1:0][COEF_W-1:0]     coefs,
	input  logic signed [OFS_W-1:0]             offset,
	output logic [PIX_W-1:0]                    res
);

	logic signed [PROD_W-1:0] prod_s1 [NUM_TAPS];
	logic signed [SUM_W-1:0]  row_s2  [3];
	logic signed [SUM_W-1:0]  tot_s3;
	logic signed [Q_W-1:0]    q_s4;
	logic [PIX_W-1:0]         res_s5;

	logic [SUM_W-1:0]         bias;
	logic [SUM_W-1:0]         adj;
	logic signed [Q_W:0]      biased;

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_TAPS; i++) begin
			prod_s1[i] <= $signed(coefs[i]) * $signed({1'b0, taps[i]});
		end
		for (int r = 0; r < 3; r++) begin
			row_s2[r] <= SUM_W'(prod_s1[r*3]) + SUM_W'(prod_s1[r*3 + 1]) +
				SUM_W'(prod_s1[r*3 + 2]);
		end
		tot_s3 <= row_s2[0] + row_s2[1] + row_s2[2];
	end

	// Round toward zero: bias negative sums by one below the divisor.
	assign bias = tot_s3[SUM_W-1] ? SUM_W'((1 << COEF_FRAC_BITS) - 1) : '0;
	assign adj  = tot_s3 + bias;

	always_ff @(posedge clk) begin
		q_s4 <= $signed(adj[SUM_W-1:COEF_FRAC_BITS]);
	end

	assign biased = (Q_W+1)'(q_s4) + (Q_W+1)'(offset);

	always_ff @(posedge clk) begin
		if (biased < 0) begin
			res_s5 <= '0;
		end else if (biased > (Q_W+1)'(PIX_MAX)) begin
			res_s5 <= PIX_W'(PIX_MAX);
		end else begin
			res_s5 <= biased[PIX_W-1:0];
		end
	end

	assign res = res_s5;

endmodule

/* src/rwf_out_fifo.sv */
// Merges the lane results into one result transaction and queues them for output.
module rwf_out_fifo import rwf_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [NUM_CH-1:0][PIX_W-1:0]  lane_res,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output result_t                       head
);

	result_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               pop;
	result_t            merged;

	assign merged.ch   = lane_res;
	assign merged.last = last;
	assign out_valid   = cnt_q != '0;
	assign pop         = out_valid && out_ready;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

endmodule

/* src/rgb_3x3_window_filter_top.sv */
// Top level of the RGB 3x3 window filter: registers, line buffer, lanes, output queue.
// The filter takes one pixel per clock in raster order while in_ready is high and
// gives one result per interior pixel; border pixels give none. A pixel passes the
// line memory read register and the window register, then the multiply, row sum,
// total, truncation and offset-saturation stages of the lane that each channel runs
// in parallel, and its result is written into the output queue. in_ready stays high
// while fewer than sixteen results are in flight or queued, so with out_ready held
// high the stream runs at one pixel per clock. The two line memories are 1024 x 24
// each and need no clearing after reset. Write the configuration registers only while
// no pixel is in flight; a mid-frame change also reaches results already in flight.
module rgb_3x3_window_filter_top import rwf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PIX_W-1:0]   pixel_ch0,
	input  logic [PIX_W-1:0]   pixel_ch1,
	input  logic [PIX_W-1:0]   pixel_ch2,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIX_W-1:0]   out_ch0,
	output logic [PIX_W-1:0]   out_ch1,
	output logic [PIX_W-1:0]   out_ch2,
	output logic               frame_last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	logic [2:0][ROW_CFG_W-1:0]   coef_rows_q;
	logic signed [OFS_W-1:0]     offset_q;
	logic [IMG_W_W-1:0]          width_q;
	logic [IMG_H_W-1:0]          height_q;

	logic                        in_fire;
	logic                        out_fire;
	logic                        produce;
	window_t                     win;
	item_flags_t                 win_flags;
	item_flags_t                 dly_q [LANE_LAT];
	logic [FIFO_AW:0]            credit_q;
	logic [NUM_TAPS-1:0][COEF_W-1:0] coefs;
	logic [NUM_CH-1:0][PIX_W-1:0]    lane_res;
	result_t                     head;

	assign cfg_ready = 1'b1;
	assign in_ready  = credit_q < (FIFO_AW+1)'(FIFO_DEPTH);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_rows_q <= '0;
			offset_q    <= '0;
			width_q     <= IMG_W_W'(1024);
			height_q    <= IMG_H_W'(1024);
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_COEF_TOP:    coef_rows_q[0] <= cfg_data[ROW_CFG_W-1:0];
				REG_COEF_MID:    coef_rows_q[1] <= cfg_data[ROW_CFG_W-1:0];
				REG_COEF_BOTTOM: coef_rows_q[2] <= cfg_data[ROW_CFG_W-1:0];
				REG_OFFSET:      offset_q       <= $signed(cfg_data[OFS_W-1:0]);
				REG_WIDTH:       width_q        <= cfg_data[IMG_W_W-1:0];
				REG_HEIGHT:      height_q       <= cfg_data[IMG_H_W-1:0];
				default: ;
			endcase
		end
	end

	// Count results in flight plus queued; hold input when the queue could overflow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + (FIFO_AW+1)'(in_fire && produce) -
				(FIFO_AW+1)'(out_fire);
		end
	end

	rwf_line_buf u_line_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.pix        ({pixel_ch2, pixel_ch1, pixel_ch0}),
		.img_width  (width_q),
		.img_height (height_q),
		.produce    (produce),
		.win        (win),
		.win_flags  (win_flags)
	);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				coefs[r*3 + c] = coef_rows_q[r][COEF_W*c +: COEF_W];
			end
		end
	end

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
		logic [NUM_TAPS-1:0][PIX_W-1:0] taps;

		always_comb begin
			for (int i = 0; i < NUM_TAPS; i++) begin
				taps[i] = win[i][PIX_W*ch +: PIX_W];
			end
		end

		rwf_lane u_lane (
			.clk    (clk),
			.taps   (taps),
			.coefs  (coefs),
			.offset (offset_q),
			.res    (lane_res[ch])
		);
	end

	// Delay the window flags to line up with the lane results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++) begin
				dly_q[i] <= '0;
			end
		end else begin
			dly_q[0] <= win_flags;
			for (int i = 1; i < LANE_LAT; i++) begin
				dly_q[i] <= dly_q[i-1];
			end
		end
	end

	rwf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (dly_q[LANE_LAT-1].valid),
		.lane_res  (lane_res),
		.last      (dly_q[LANE_LAT-1].last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign out_ch0    = head.ch[0];
	assign out_ch1    = head.ch[1];
	assign out_ch2    = head.ch[2];
	assign frame_last = head.last;

endmodule
